// ----- rtl/core/gbn_pkg.sv -----
// Shared widths, codes, defaults and types for the Go-Back-N sender window unit.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int IDX_W      = 15;
	localparam int LEN_W      = 11;
	localparam int FL_W       = 24;
	localparam int WS_W       = 5;
	localparam int TO_W       = 16;
	localparam int TICK_W     = 17;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int PAYLOAD_BYTES_DEF = 1024;
	localparam int MAX_WINDOW_DEF    = 16;
	localparam int MAX_PACKETS_DEF   = 16384;

	localparam logic [OP_W-1:0] OP_SEND = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	localparam logic [WS_W-1:0] WINDOW_SIZE_RST   = 5'd5;
	localparam logic [FL_W-1:0] FILE_LENGTH_RST   = 24'd0;
	localparam logic [TO_W-1:0] TIMEOUT_TICKS_RST = 16'd200;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             le;
		logic             fin;
		logic [LEN_W-1:0] len;
	} gbn_cls_t;

endpackage

// ----- rtl/core/gbn_len_unit.sv -----
// Shared multiply-and-compare unit that classifies one packet index and gives its length.
`timescale 1ns / 1ps

module gbn_len_unit #(
	parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF,
	parameter int MAX_PACKETS   = gbn_pkg::MAX_PACKETS_DEF
) (
	input  logic                        clk,
	input  logic                        ld,
	input  logic [gbn_pkg::IDX_W-1:0]   idx,
	input  logic [gbn_pkg::FL_W-1:0]    file_length,
	output gbn_pkg::gbn_cls_t           cls
);

	localparam int PB_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int PR_W = gbn_pkg::IDX_W + PB_W;
	localparam int CW   = ((PR_W > gbn_pkg::FL_W) ? PR_W : gbn_pkg::FL_W) + 1;
	localparam logic [CW-1:0] PB_C = CW'(PAYLOAD_BYTES);
	localparam logic [17:0]   MP_C = 18'(MAX_PACKETS);

	logic [gbn_pkg::IDX_W-1:0] idx_s1;
	logic [PR_W-1:0]           prod_s1;
	logic [CW-1:0]             prod_c;
	logic [CW-1:0]             prev_c;
	logic [CW-1:0]             fl_c;
	logic [CW-1:0]             diff_c;
	logic                      lt;
	logic                      le;
	logic                      fin;

	always_ff @(posedge clk) begin
		if (ld) begin
			idx_s1  <= idx;
			prod_s1 <= PR_W'(idx) * PR_W'(PAYLOAD_BYTES);
		end
	end

	// An index lies below the packet count when its end offset is still short of the file.
	always_comb begin
		prod_c = CW'(prod_s1);
		prev_c = prod_c - PB_C;
		fl_c   = CW'(file_length);
		diff_c = fl_c - prev_c;
		lt     = (prod_c < fl_c) && (18'(idx_s1) < MP_C);
		le     = lt || ((prev_c < fl_c) && (18'(idx_s1) <= MP_C));
		fin    = le && !lt;
		cls.idx = idx_s1;
		cls.le  = le;
		cls.fin = fin;
		if (lt) begin
			cls.len = PB_C[gbn_pkg::LEN_W-1:0];
		end else if (fin) begin
			cls.len = diff_c[gbn_pkg::LEN_W-1:0];
		end else begin
			cls.len = '0;
		end
	end

endmodule

// ----- rtl/core/gbn_ctrl.sv -----
// Sequencer holding the window state and driving the shared unit and the result registers.
`timescale 1ns / 1ps

module gbn_ctrl #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gbn_pkg::OP_W-1:0]   opcode,
	input  logic [gbn_pkg::IDX_W-1:0]  ack_number,
	input  logic                       ack_good,
	input  logic [gbn_pkg::WS_W-1:0]   window_size,
	input  logic [gbn_pkg::TO_W-1:0]   timeout_ticks,
	input  gbn_pkg::gbn_cls_t          cls,
	output logic                       ld,
	output logic [gbn_pkg::IDX_W-1:0]  idx,
	output logic                       busy,
	output logic                       result_valid,
	output logic [gbn_pkg::IDX_W-1:0]  packet_index,
	output logic [gbn_pkg::LEN_W-1:0]  packet_length,
	output logic                       final_packet,
	output logic                       retransmit,
	output logic                       run_last
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_WINDOW - 1);
	localparam logic [16:0] WIN_MAX = 17'(MAX_WINDOW);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BASE = 4'b0010,
		ST_SEND = 4'b0100,
		ST_RES  = 4'b1000
	} gbn_state_t;

	gbn_state_t                 state_q, state_d;
	logic [gbn_pkg::OP_W-1:0]   op_q;
	logic [gbn_pkg::IDX_W-1:0]  ack_q;
	logic                       good_q;
	logic [gbn_pkg::IDX_W-1:0]  base_q, base_d;
	logic [gbn_pkg::IDX_W-1:0]  next_q, next_d;
	logic [gbn_pkg::TICK_W-1:0] el_q, el_d;
	logic [gbn_pkg::TICK_W-1:0] tick_nxt;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic [16:0]                win;
	logic [16:0]                limit;
	logic                       emit;
	logic                       emit_retx;
	logic                       emit_last;
	logic                       last_res;

	always_comb begin
		if (window_size == '0) begin
			win = 17'd1;
		end else if (17'(window_size) > WIN_MAX) begin
			win = WIN_MAX;
		end else begin
			win = 17'(window_size);
		end
		limit    = 17'(base_q) + win;
		tick_nxt = (el_q == '1) ? el_q : el_q + 1'b1;
		last_res = ((17'(cls.idx) + 17'd1) == 17'(next_q)) || (cnt_q == CNT_LAST);
	end

	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		next_d    = next_q;
		el_d      = el_q;
		cnt_d     = cnt_q;
		ld        = 1'b0;
		idx       = base_q;
		emit      = 1'b0;
		emit_retx = 1'b0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ld      = 1'b1;
					state_d = ST_BASE;
				end
			end
			ST_BASE: begin
				state_d = ST_IDLE;
				if (cls.le) begin
					case (op_q)
						gbn_pkg::OP_SEND: begin
							if (17'(next_q) < limit) begin
								ld      = 1'b1;
								idx     = next_q;
								state_d = ST_SEND;
							end
						end
						gbn_pkg::OP_ACK: begin
							if (good_q && (ack_q == base_q) && (base_q < next_q)) begin
								base_d = base_q + 1'b1;
								el_d   = '0;
							end
						end
						gbn_pkg::OP_TICK: begin
							if (tick_nxt > gbn_pkg::TICK_W'(timeout_ticks)) begin
								el_d = '0;
								if (base_q < next_q) begin
									ld      = 1'b1;
									cnt_d   = '0;
									state_d = ST_RES;
								end
							end else begin
								el_d = tick_nxt;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SEND: begin
				state_d = ST_IDLE;
				if (cls.le) begin
					emit   = 1'b1;
					next_d = next_q + 1'b1;
				end
			end
			ST_RES: begin
				emit      = 1'b1;
				emit_retx = 1'b1;
				emit_last = last_res;
				if (last_res) begin
					state_d = ST_IDLE;
				end else begin
					ld    = 1'b1;
					idx   = cls.idx + 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_q       <= gbn_pkg::IDX_W'(1);
			next_q       <= gbn_pkg::IDX_W'(1);
			el_q         <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			base_q       <= base_d;
			next_q       <= next_d;
			el_q         <= el_d;
			cnt_q        <= cnt_d;
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= opcode;
			ack_q  <= ack_number;
			good_q <= ack_good;
		end
		if (emit) begin
			packet_index  <= cls.idx;
			packet_length <= cls.len;
			final_packet  <= cls.fin;
			retransmit    <= emit_retx;
			run_last      <= emit_last;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/core/go_back_n_sender_window_unit.sv -----
// Top level of the Go-Back-N sender window unit with its configuration registers.
// An acknowledgement, a plain tick or a refused word is done in the base state, which classifies the base index.
// A send inside the window then classifies the next index in the send state; its result shows as busy falls.
// A timeout resend of n packets runs through the resend state and shows one result a cycle.
// Each index passes the registered multiply by the payload size in the shared unit first.
// Reset clears the window to base 1, next index 1 and the timer; the receiver cannot stall.
`timescale 1ns / 1ps

module go_back_n_sender_window_unit #(
	parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF,
	parameter int MAX_WINDOW    = gbn_pkg::MAX_WINDOW_DEF,
	parameter int MAX_PACKETS   = gbn_pkg::MAX_PACKETS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [gbn_pkg::OP_W-1:0]        opcode,
	input  logic [gbn_pkg::IDX_W-1:0]       ack_number,
	input  logic                            ack_good,
	input  logic                            cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            result_valid,
	output logic [gbn_pkg::IDX_W-1:0]       packet_index,
	output logic [gbn_pkg::LEN_W-1:0]       packet_length,
	output logic                            final_packet,
	output logic                            retransmit,
	output logic                            run_last
);

	logic [gbn_pkg::WS_W-1:0]  window_size_q;
	logic [gbn_pkg::FL_W-1:0]  file_length_q;
	logic [gbn_pkg::TO_W-1:0]  timeout_ticks_q;
	logic                      ld;
	logic [gbn_pkg::IDX_W-1:0] idx;
	gbn_pkg::gbn_cls_t         cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= gbn_pkg::WINDOW_SIZE_RST;
			file_length_q   <= gbn_pkg::FILE_LENGTH_RST;
			timeout_ticks_q <= gbn_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::REG_WINDOW_SIZE: begin
					window_size_q <= cfg_data[gbn_pkg::WS_W-1:0];
				end
				gbn_pkg::REG_FILE_LENGTH: begin
					file_length_q <= cfg_data[gbn_pkg::FL_W-1:0];
				end
				gbn_pkg::REG_TIMEOUT_TICKS: begin
					timeout_ticks_q <= cfg_data[gbn_pkg::TO_W-1:0];
				end
				default: begin
					timeout_ticks_q <= timeout_ticks_q;
				end
			endcase
		end
	end

	gbn_ctrl #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.opcode        (opcode),
		.ack_number    (ack_number),
		.ack_good      (ack_good),
		.window_size   (window_size_q),
		.timeout_ticks (timeout_ticks_q),
		.cls           (cls),
		.ld            (ld),
		.idx           (idx),
		.busy          (busy),
		.result_valid  (result_valid),
		.packet_index  (packet_index),
		.packet_length (packet_length),
		.final_packet  (final_packet),
		.retransmit    (retransmit),
		.run_last      (run_last)
	);

	gbn_len_unit #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.MAX_PACKETS   (MAX_PACKETS)
	) u_len (
		.clk         (clk),
		.ld          (ld),
		.idx         (idx),
		.file_length (file_length_q),
		.cls         (cls)
	);

endmodule

// ----- rtl/core/gbn_checker.sv -----
// Port-level checker for the Go-Back-N sender window unit and its bind statement.
`timescale 1ns / 1ps

module gbn_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [gbn_pkg::IDX_W-1:0]  packet_index,
	input logic                       retransmit,
	input logic                       run_last
);

	// Every accepted word holds the block busy in the following cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted word");

	// A word accepted while idle never finds a result showing in the next cycle.
	a_no_stale_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid)
		else $error("result shown right after an accepted word");

	// A first send is always a single result.
	a_send_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !retransmit |-> run_last)
		else $error("first send not marked as last result");

	// A resend burst runs without gaps over consecutive indices.
	a_burst_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !run_last |=> result_valid && retransmit &&
		(packet_index == gbn_pkg::IDX_W'($past(packet_index) + 1'b1)))
		else $error("resend burst broken");

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);
